/* rtl/bbm_pkg.sv */
// Shared types, field widths and codes of the binary box morphology block.
package bbm_pkg;

	localparam int ACTION_W    = 1;
	localparam int POS_X_W     = 6;
	localparam int POS_Y_W     = 6;
	localparam int POS_Z_W     = 4;
	localparam int VOXEL_W     = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 7;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OP_MODE,
		REG_WINDOW_RADIUS,
		REG_USE_DEPTH,
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z
	} reg_index_t;

	// Operation codes; the unused code behaves as a majority vote.
	localparam logic [1:0] OP_ERODE    = 2'd0;
	localparam logic [1:0] OP_DILATE   = 2'd1;
	localparam logic [1:0] OP_MAJORITY = 2'd2;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [1:0] RST_OP_MODE       = OP_ERODE;
	localparam logic [2:0] RST_WINDOW_RADIUS = 3'd1;
	localparam logic       RST_USE_DEPTH     = 1'b0;
	localparam logic [6:0] RST_SIZE_X        = 7'd64;
	localparam logic [6:0] RST_SIZE_Y        = 7'd64;
	localparam logic [4:0] RST_SIZE_Z        = 5'd16;

	typedef struct packed {
		logic [1:0] op_mode;
		logic [2:0] window_radius;
		logic       use_depth;
		logic [6:0] size_x;
		logic [6:0] size_y;
		logic [4:0] size_z;
	} cfg_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [POS_X_W-1:0]  pos_x;
		logic [POS_Y_W-1:0]  pos_y;
		logic [POS_Z_W-1:0]  pos_z;
		logic [VOXEL_W-1:0]  voxel_value;
	} item_t;

	// Control from the sequencer to the window counter.
	typedef struct packed {
		logic start;
		logic issue;
		logic last;
	} cnt_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_READ,
		ST_WR_MOD,
		ST_Q_SETUP,
		ST_Q_RUN,
		ST_Q_DRAIN
	} state_t;

endpackage

/* rtl/bbm_in_if.sv */
// Input channel: voxel write and query beats.
interface bbm_in_if import bbm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [POS_X_W-1:0]  pos_x;
	logic [POS_Y_W-1:0]  pos_y;
	logic [POS_Z_W-1:0]  pos_z;
	logic [VOXEL_W-1:0]  voxel_value;

	modport source (output valid, action, pos_x, pos_y, pos_z, voxel_value, input ready);
	modport sink (input valid, action, pos_x, pos_y, pos_z, voxel_value, output ready);
endinterface

/* rtl/bbm_out_if.sv */
// Output channel: one result bit per query.
interface bbm_out_if;
	logic valid;
	logic ready;
	logic result_bit;

	modport source (output valid, result_bit, input ready);
	modport sink (input valid, result_bit, output ready);
endinterface

/* rtl/bbm_row_mem.sv */
// Synchronous row memory holding one bit per voxel, one row word per entry.
module bbm_row_mem #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] row_mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			row_mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= row_mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/bbm_win_count.sv */
// Window counter: masks each returned row to the window columns and sums the ones.
module bbm_win_count import bbm_pkg::*; #(
	parameter int ROW_BITS   = 64,
	parameter int MAX_RADIUS = 5
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  cnt_ctl_t                                        ctl,
	input  logic [$clog2(ROW_BITS)-1:0]                     x0,
	input  logic [$clog2(2*MAX_RADIUS+2)-1:0]               xlen,
	input  logic [ROW_BITS-1:0]                             rdata,
	output logic [$clog2((2*MAX_RADIUS+1)**3+1)-1:0]        ones,
	output logic [$clog2((2*MAX_RADIUS+1)**3+1)-1:0]        total,
	output logic                                            done
);

	localparam int WIN   = 2*MAX_RADIUS + 1;
	localparam int LW    = $clog2(WIN + 1);
	localparam int CNT_W = $clog2(WIN**3 + 1);
	localparam int EXT   = ROW_BITS + WIN;

	logic             issue_s1, last_s1;
	logic             valid_s2, last_s2;
	logic [LW-1:0]    pc_s2;
	logic [EXT-1:0]   shifted_c;
	logic [WIN-1:0]   win_c;
	logic [LW-1:0]    pc_c;
	logic [CNT_W-1:0] ones_q, total_q;
	logic             done_q;

	// The row is padded so that a window reaching past a narrow row still reads zeros.
	always_comb begin
		shifted_c = {{WIN{1'b0}}, rdata} >> x0;
		win_c     = shifted_c[WIN-1:0] & ~({WIN{1'b1}} << xlen);
		pc_c      = '0;
		for (int i = 0; i < WIN; i++) begin
			pc_c = pc_c + LW'(win_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			ones_q   <= '0;
			total_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			issue_s1 <= ctl.issue;
			last_s1  <= ctl.issue & ctl.last;
			valid_s2 <= issue_s1;
			last_s2  <= last_s1;
			if (ctl.start) begin
				ones_q  <= '0;
				total_q <= '0;
				done_q  <= 1'b0;
			end else if (valid_s2) begin
				ones_q  <= ones_q + CNT_W'(pc_s2);
				total_q <= total_q + CNT_W'(xlen);
				if (last_s2) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_s1) begin
			pc_s2 <= pc_c;
		end
	end

	assign ones  = ones_q;
	assign total = total_q;
	assign done  = done_q;

endmodule

/* rtl/bbm_seq.sv */
// Sequencer: read-modify-write of voxel writes and the row sweep of queries.
module bbm_seq import bbm_pkg::*; #(
	parameter int ROW_BITS   = 64,
	parameter int MAX_ROWS   = 64,
	parameter int MAX_SLICES = 16,
	parameter int MAX_RADIUS = 5
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  cfg_t                                          cfg,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  item_t                                         item,
	output logic                                          mem_we,
	output logic [$clog2(MAX_SLICES*MAX_ROWS)-1:0]        mem_waddr,
	output logic [ROW_BITS-1:0]                           mem_wdata,
	output logic                                          mem_re,
	output logic [$clog2(MAX_SLICES*MAX_ROWS)-1:0]        mem_raddr,
	input  logic [ROW_BITS-1:0]                           mem_rdata,
	output cnt_ctl_t                                      cnt_ctl,
	output logic [$clog2(ROW_BITS)-1:0]                   x0,
	output logic [$clog2(2*MAX_RADIUS+2)-1:0]             xlen,
	input  logic [$clog2((2*MAX_RADIUS+1)**3+1)-1:0]      ones,
	input  logic [$clog2((2*MAX_RADIUS+1)**3+1)-1:0]      total,
	input  logic                                          cnt_done,
	input  logic                                          out_free,
	output logic                                          res_load,
	output logic                                          res_bit
);

	localparam int XW    = $clog2(ROW_BITS);
	localparam int YW    = $clog2(MAX_ROWS);
	localparam int ZW    = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam int AW    = $clog2(MAX_SLICES*MAX_ROWS);
	localparam int WIN   = 2*MAX_RADIUS + 1;
	localparam int LW    = $clog2(WIN + 1);
	localparam int CNT_W = $clog2(WIN**3 + 1);
	localparam int LIM_A = (ROW_BITS > MAX_ROWS) ? ROW_BITS : MAX_ROWS;
	localparam int LIM_B = (LIM_A > MAX_SLICES) ? LIM_A : MAX_SLICES;
	localparam int LIM   = (LIM_B > 128) ? LIM_B : 128;
	localparam int CW    = $clog2(LIM + MAX_RADIUS + 1) + 2;

	state_t                state_q, state_d;
	item_t                 item_q;
	logic                  oor_q;
	logic [XW-1:0]         x0_q;
	logic [LW-1:0]         xlen_q;
	logic [YW-1:0]         y0_q, y1_q, y_q;
	logic [ZW-1:0]         z1_q, z_q;

	logic signed [CW-1:0]  px, py, pz, nx, ny, nz, r, rz;
	logic signed [CW-1:0]  xlo, xhi, ylo, yhi, zlo, zhi, xlen_c;
	logic                  oor_c, wr_ok_c, last_row_c, vote_c;
	logic [AW-1:0]         wr_addr_c, run_addr_c;
	logic [ROW_BITS-1:0]   bit_mask_c;

	// A size of zero acts as one, a size past the storage as the storage limit.
	function automatic logic signed [CW-1:0] clamp_size(input logic [CFG_DATA_W-1:0] raw,
			input int lim);
		logic signed [CW-1:0] v;
		if (raw == '0) begin
			v = CW'(1);
		end else if (CW'(raw) > CW'(lim)) begin
			v = CW'(lim);
		end else begin
			v = signed'(CW'(raw));
		end
		return v;
	endfunction

	function automatic logic signed [CW-1:0] low_bound(input logic signed [CW-1:0] p,
			input logic signed [CW-1:0] rad);
		logic signed [CW-1:0] lo;
		lo = p - rad;
		return (lo < 0) ? CW'(0) : lo;
	endfunction

	function automatic logic signed [CW-1:0] high_bound(input logic signed [CW-1:0] p,
			input logic signed [CW-1:0] rad, input logic signed [CW-1:0] n);
		logic signed [CW-1:0] hi;
		hi = p + rad;
		return (hi >= n) ? n - CW'(1) : hi;
	endfunction

	// Window bounds of the held query.
	always_comb begin
		px = signed'(CW'(item_q.pos_x));
		py = signed'(CW'(item_q.pos_y));
		pz = signed'(CW'(item_q.pos_z));
		nx = clamp_size(CFG_DATA_W'(cfg.size_x), ROW_BITS);
		ny = clamp_size(CFG_DATA_W'(cfg.size_y), MAX_ROWS);
		nz = clamp_size(CFG_DATA_W'(cfg.size_z), MAX_SLICES);
		if (cfg.window_radius == '0) begin
			r = CW'(1);
		end else if (CW'(cfg.window_radius) > CW'(MAX_RADIUS)) begin
			r = CW'(MAX_RADIUS);
		end else begin
			r = signed'(CW'(cfg.window_radius));
		end
		rz      = cfg.use_depth ? r : CW'(0);
		xlo     = low_bound(px, r);
		xhi     = high_bound(px, r, nx);
		ylo     = low_bound(py, r);
		yhi     = high_bound(py, r, ny);
		zlo     = low_bound(pz, rz);
		zhi     = high_bound(pz, rz, nz);
		xlen_c  = xhi - xlo + CW'(1);
		oor_c   = (px >= nx) || (py >= ny) || (pz >= nz);
		wr_ok_c = (px < CW'(ROW_BITS)) && (py < CW'(MAX_ROWS)) && (pz < CW'(MAX_SLICES));
	end

	assign wr_addr_c  = AW'(item_q.pos_z) * AW'(MAX_ROWS) + AW'(item_q.pos_y);
	assign run_addr_c = AW'(z_q) * AW'(MAX_ROWS) + AW'(y_q);
	assign last_row_c = (y_q == y1_q) && (z_q == z1_q);
	assign bit_mask_c = {{(ROW_BITS-1){1'b0}}, 1'b1} << item_q.pos_x;
	assign vote_c     = {ones, 1'b0} >= {1'b0, total};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item;
		end
		if (state_q == ST_Q_SETUP) begin
			oor_q  <= oor_c;
			x0_q   <= xlo[XW-1:0];
			xlen_q <= xlen_c[LW-1:0];
			y0_q   <= ylo[YW-1:0];
			y1_q   <= yhi[YW-1:0];
			z1_q   <= zhi[ZW-1:0];
			y_q    <= ylo[YW-1:0];
			z_q    <= zlo[ZW-1:0];
		end else if (state_q == ST_Q_RUN) begin
			if (y_q == y1_q) begin
				y_q <= y0_q;
				z_q <= z_q + ZW'(1);
			end else begin
				y_q <= y_q + YW'(1);
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_raddr     = wr_addr_c;
		cnt_ctl.start = 1'b0;
		cnt_ctl.issue = 1'b0;
		cnt_ctl.last  = last_row_c;
		res_load      = 1'b0;
		res_bit       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (item.action == ACT_QUERY) ? ST_Q_SETUP : ST_WR_READ;
				end
			end
			ST_WR_READ: begin
				mem_re  = wr_ok_c;
				state_d = wr_ok_c ? ST_WR_MOD : ST_IDLE;
			end
			ST_WR_MOD: begin
				mem_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_Q_SETUP: begin
				cnt_ctl.start = 1'b1;
				state_d       = oor_c ? ST_Q_DRAIN : ST_Q_RUN;
			end
			ST_Q_RUN: begin
				mem_re        = 1'b1;
				mem_raddr     = run_addr_c;
				cnt_ctl.issue = 1'b1;
				if (last_row_c) begin
					state_d = ST_Q_DRAIN;
				end
			end
			ST_Q_DRAIN: begin
				if ((oor_q || cnt_done) && out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
				if (!oor_q) begin
					case (cfg.op_mode)
						OP_ERODE:  res_bit = (ones == total);
						OP_DILATE: res_bit = (ones != '0);
						default:   res_bit = vote_c;
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign mem_waddr = wr_addr_c;
	assign mem_wdata = (item_q.voxel_value != '0) ? (mem_rdata | bit_mask_c)
	                                              : (mem_rdata & ~bit_mask_c);
	assign x0        = x0_q;
	assign xlen      = xlen_q;

endmodule

/* rtl/binary_box_morphology.sv */
// A write reads its row and writes the modified word back; no other beat is taken meanwhile.
// A query inside the volume sweeps its window rows through the single read port of the voxel
// memory: up to (2r+1) rows in-slice or (2r+1)^2 across slices, fewer where the volume clips.
// Its result is loaded once the last row has been counted and the output register is free.
// A query outside the volume in use reads no rows and is answered once the output register is free.
// Reset clears control and configuration; the voxel memory is not cleared.
module binary_box_morphology import bbm_pkg::*; #(
	parameter int ROW_BITS   = 64,
	parameter int MAX_ROWS   = 64,
	parameter int MAX_SLICES = 16,
	parameter int MAX_RADIUS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	bbm_in_if.sink                 in_ch,
	bbm_out_if.source              out_ch
);

	localparam int DEPTH = MAX_SLICES * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(ROW_BITS);
	localparam int LW    = $clog2(2*MAX_RADIUS + 2);
	localparam int CNT_W = $clog2((2*MAX_RADIUS+1)**3 + 1);

	// Configuration registers, to be written only while the block is idle; the block does not enforce it.
	logic [1:0] op_mode_q;
	logic [2:0] window_radius_q;
	logic       use_depth_q;
	logic [6:0] size_x_q, size_y_q;
	logic [4:0] size_z_q;
	cfg_t       cfg;

	item_t             item;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [ROW_BITS-1:0] mem_wdata, mem_rdata;
	cnt_ctl_t          cnt_ctl;
	logic [XW-1:0]     x0;
	logic [LW-1:0]     xlen;
	logic [CNT_W-1:0]  ones, total;
	logic              cnt_done;
	logic              out_free, res_load, res_bit;
	logic              out_valid_q, result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q       <= RST_OP_MODE;
			window_radius_q <= RST_WINDOW_RADIUS;
			use_depth_q     <= RST_USE_DEPTH;
			size_x_q        <= RST_SIZE_X;
			size_y_q        <= RST_SIZE_Y;
			size_z_q        <= RST_SIZE_Z;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OP_MODE:       op_mode_q       <= cfg_data[1:0];
				REG_WINDOW_RADIUS: window_radius_q <= cfg_data[2:0];
				REG_USE_DEPTH:     use_depth_q     <= cfg_data[0];
				REG_SIZE_X:        size_x_q        <= cfg_data;
				REG_SIZE_Y:        size_y_q        <= cfg_data;
				REG_SIZE_Z:        size_z_q        <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = '{op_mode: op_mode_q, window_radius: window_radius_q,
		use_depth: use_depth_q, size_x: size_x_q, size_y: size_y_q, size_z: size_z_q};

	assign item = '{action: in_ch.action, pos_x: in_ch.pos_x, pos_y: in_ch.pos_y,
		pos_z: in_ch.pos_z, voxel_value: in_ch.voxel_value};

	// The sequencer owns the memory ports: a write is a read of the row followed by a
	// write-back of the modified word; a query sweeps the window rows one per cycle.
	// Only one item is in flight, so a row is never read while its update is pending.
	bbm_seq #(
		.ROW_BITS  (ROW_BITS),
		.MAX_ROWS  (MAX_ROWS),
		.MAX_SLICES(MAX_SLICES),
		.MAX_RADIUS(MAX_RADIUS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.item     (item),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.cnt_ctl  (cnt_ctl),
		.x0       (x0),
		.xlen     (xlen),
		.ones     (ones),
		.total    (total),
		.cnt_done (cnt_done),
		.out_free (out_free),
		.res_load (res_load),
		.res_bit  (res_bit)
	);

	bbm_row_mem #(
		.WIDTH(ROW_BITS),
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Each returned row is cut to the window columns and its ones are summed, with the
	// count of visited voxels kept alongside for the majority vote and erosion.
	bbm_win_count #(
		.ROW_BITS  (ROW_BITS),
		.MAX_RADIUS(MAX_RADIUS)
	) u_count (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (cnt_ctl),
		.x0    (x0),
		.xlen  (xlen),
		.rdata (mem_rdata),
		.ones  (ones),
		.total (total),
		.done  (cnt_done)
	);

	// The output register lets a new beat enter while a result still waits to be taken.
	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res_bit;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.result_bit = result_q;

endmodule

/* rtl/bbm_checker.sv */
// Port-level checks of the binary box morphology block and their binding.
module bbm_checker import bbm_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [ACTION_W-1:0] in_action,
	input logic                out_valid,
	input logic                out_ready,
	input logic                result_bit
);

	// A result that is not taken stays, unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_bit))
		else $error("result beat dropped or changed while stalled");

	// One item at a time: the cycle after a beat is taken, no other is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is still in work");

	// A write produces no result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action == ACT_WRITE |=>
			!$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared after a voxel write");

	// A new result is loaded only at the end of a query, while input is held off.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result loaded while the block was idle");

endmodule

bind binary_box_morphology bbm_checker u_bbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_action (in_ch.action),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.result_bit(out_ch.result_bit)
);

/* verif/binary_box_morphology_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the binary box morphology block: predicts every query result.
module binary_box_morphology_tb;
	import bbm_pkg::*;

	// Storage limits of the instance under test, also used by the predictor.
	localparam int ROW_LIMIT    = 64;
	localparam int ROW_COUNT    = 64;
	localparam int SLICE_LIMIT  = 16;
	localparam int RADIUS_LIMIT = 5;

	// The package names no code for the spare operation; it votes like majority.
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam int RANDOM_ITEMS = 600;
	localparam int CFG_SETTLE   = 8;
	localparam int END_DRAIN    = 140;
	localparam int QUIET_LIMIT  = 2000;
	localparam int REPORT_LIMIT = 10;

	// One outstanding query: where it looked and what it should answer.
	typedef struct packed {
		logic [POS_X_W-1:0] pos_x;
		logic [POS_Y_W-1:0] pos_y;
		logic [POS_Z_W-1:0] pos_z;
		logic               result_bit;
	} answer_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	bbm_in_if  voxel_ch ();
	bbm_out_if result_ch ();

	binary_box_morphology #(
		.ROW_BITS  (ROW_LIMIT),
		.MAX_ROWS  (ROW_COUNT),
		.MAX_SLICES(SLICE_LIMIT),
		.MAX_RADIUS(RADIUS_LIMIT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (voxel_ch),
		.out_ch   (result_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stimulus side: beats waiting for the driver, the settings last programmed, and which
	// voxels have been given a value so that no query ever looks at an unwritten voxel.
	item_t      voxel_beats_q [$];
	item_t      next_beat;
	cfg_t       plan_cfg;
	bit  [63:0] written_rows [SLICE_LIMIT][ROW_COUNT];
	int         fill_density;
	int         stim_items;

	// Prediction side: its own copy of the volume and of the registers, as seen on the ports.
	bit  [63:0] shadow_volume [SLICE_LIMIT][ROW_COUNT];
	cfg_t       live_cfg;
	answer_t    pending_answers [$];
	answer_t    fresh_answer;
	answer_t    oldest_answer;

	int beats_sent;
	int beats_taken;
	int send_gap;
	int send_steady;
	int hold_left;
	int ready_steady;
	int quiet_cycles;
	int fail_count;

	// A size of zero acts as one, and anything above the storage limit acts as the limit.
	function automatic int eff_size(input int raw, input int limit);
		if (raw == 0) return 1;
		if (raw > limit) return limit;
		return raw;
	endfunction

	// Clipped window bounds around a voxel; returns 0 when the voxel lies outside the
	// volume in use, in which case the bounds are meaningless.
	function automatic bit window_span(input cfg_t c, input int px, input int py, input int pz,
			output int x0, output int x1, output int y0, output int y1,
			output int z0, output int z1);
		int nx, ny, nz, r, rz;
		nx = eff_size(c.size_x, ROW_LIMIT);
		ny = eff_size(c.size_y, ROW_COUNT);
		nz = eff_size(c.size_z, SLICE_LIMIT);
		r = c.window_radius;
		if (r < 1) r = 1;
		if (r > RADIUS_LIMIT) r = RADIUS_LIMIT;
		rz = c.use_depth ? r : 0;
		x0 = (px - r < 0) ? 0 : px - r;
		x1 = (px + r >= nx) ? nx - 1 : px + r;
		y0 = (py - r < 0) ? 0 : py - r;
		y1 = (py + r >= ny) ? ny - 1 : py + r;
		z0 = (pz - rz < 0) ? 0 : pz - rz;
		z1 = (pz + rz >= nz) ? nz - 1 : pz + rz;
		return (px < nx && py < ny && pz < nz);
	endfunction

	// Expected answer of a query under the registers currently in force.
	function automatic bit box_result(input int px, input int py, input int pz);
		int x0, x1, y0, y1, z0, z1;
		int ones, zeros;
		if (!window_span(live_cfg, px, py, pz, x0, x1, y0, y1, z0, z1)) return 1'b0;
		ones = 0;
		zeros = 0;
		for (int z = z0; z <= z1; z++)
			for (int y = y0; y <= y1; y++)
				for (int x = x0; x <= x1; x++) begin
					if (shadow_volume[z][y][x]) ones++;
					else zeros++;
				end
		case (live_cfg.op_mode)
			OP_ERODE:  return zeros == 0;
			OP_DILATE: return ones != 0;
			default:   return ones >= zeros;
		endcase
	endfunction

	// Mostly short pauses, a few long ones, and now and then a stretch of none at all.
	function automatic int pick_pause(inout int steady);
		int roll;
		if (steady > 0) begin
			steady--;
			return 0;
		end
		roll = $urandom_range(99);
		if (roll < 2) begin
			steady = $urandom_range(30, 80);
			return 0;
		end
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_density();
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return 10;
			2:       return 50;
			3:       return 90;
			default: return 100;
		endcase
	endfunction

	function automatic logic [VOXEL_W-1:0] fill_byte(input int density);
		if (int'($urandom_range(99)) < density) return VOXEL_W'($urandom_range(1, 255));
		return '0;
	endfunction

	// Register value for a size: zero, above the limit, the limit, or anything in range.
	function automatic int pick_size(input int limit, input int top);
		int roll;
		roll = $urandom_range(99);
		if (roll < 10) return 0;
		if (roll < 20) return $urandom_range(limit + 1, top);
		if (roll < 35) return limit;
		return $urandom_range(1, limit);
	endfunction

	function automatic int pick_focus(input int n, input bit hug_corner);
		int roll;
		if (hug_corner) return $urandom_range(1) ? n - 1 : 0;
		roll = $urandom_range(99);
		if (roll < 25) return 0;
		if (roll < 50) return n - 1;
		return $urandom_range(0, n - 1);
	endfunction

	// A coordinate within two of the focus, kept inside the volume in use.
	function automatic int near_focus(input int centre, input int n);
		int v;
		v = centre + int'($urandom_range(0, 4)) - 2;
		if (v < 0) v = 0;
		if (v > n - 1) v = n - 1;
		return v;
	endfunction

	function automatic void queue_write(input int x, input int y, input int z,
			input logic [VOXEL_W-1:0] value);
		item_t beat;
		beat.action      = ACT_WRITE;
		beat.pos_x       = x[POS_X_W-1:0];
		beat.pos_y       = y[POS_Y_W-1:0];
		beat.pos_z       = z[POS_Z_W-1:0];
		beat.voxel_value = value;
		voxel_beats_q = {voxel_beats_q, beat};
		written_rows[z][y][x] = 1'b1;
		stim_items++;
	endfunction

	// Any voxel of the window that has never been written gets a value first.
	function automatic void queue_query(input int x, input int y, input int z);
		item_t beat;
		int x0, x1, y0, y1, z0, z1;
		if (window_span(plan_cfg, x, y, z, x0, x1, y0, y1, z0, z1))
			for (int zz = z0; zz <= z1; zz++)
				for (int yy = y0; yy <= y1; yy++)
					for (int xx = x0; xx <= x1; xx++)
						if (!written_rows[zz][yy][xx])
							queue_write(xx, yy, zz, fill_byte(fill_density));
		beat.action      = ACT_QUERY;
		beat.pos_x       = x[POS_X_W-1:0];
		beat.pos_y       = y[POS_Y_W-1:0];
		beat.pos_z       = z[POS_Z_W-1:0];
		beat.voxel_value = VOXEL_W'($urandom_range(0, 255));
		voxel_beats_q = {voxel_beats_q, beat};
		stim_items++;
	endfunction

	// Wait until every beat is taken and every answer is in, then let the block go quiet.
	task automatic settle(input int extra);
		while (voxel_beats_q.size() != 0 || beats_taken != beats_sent ||
				pending_answers.size() != 0)
			@(negedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	// Registers change only with the block idle; every register is rewritten each time.
	task automatic apply_setting(input cfg_t s);
		settle(CFG_SETTLE);
		write_reg(REG_OP_MODE, CFG_DATA_W'(s.op_mode));
		write_reg(REG_WINDOW_RADIUS, CFG_DATA_W'(s.window_radius));
		write_reg(REG_USE_DEPTH, CFG_DATA_W'(s.use_depth));
		write_reg(REG_SIZE_X, CFG_DATA_W'(s.size_x));
		write_reg(REG_SIZE_Y, CFG_DATA_W'(s.size_y));
		write_reg(REG_SIZE_Z, CFG_DATA_W'(s.size_z));
		@(negedge clk);
		cfg_we <= 1'b0;
		plan_cfg = s;
	endtask

	// One phase of random work around a focus point: painted boxes with a query in them,
	// queries near the focus, stray writes anywhere in storage and queries outside the
	// volume in use. Work stays near the focus so that fill writes are shared.
	task automatic run_phase(input bit hug_corner);
		int nx, ny, nz, fx, fy, fz, roll;
		int bx, by, bz, w, h, d, paint;
		int qx, qy, qz;
		nx = eff_size(plan_cfg.size_x, ROW_LIMIT);
		ny = eff_size(plan_cfg.size_y, ROW_COUNT);
		nz = eff_size(plan_cfg.size_z, SLICE_LIMIT);
		fx = pick_focus(nx, hug_corner);
		fy = pick_focus(ny, hug_corner);
		fz = pick_focus(nz, hug_corner);
		fill_density = pick_density();
		repeat ($urandom_range(12, 30)) begin
			roll = $urandom_range(99);
			if (roll < 25) begin
				bx = near_focus(fx, nx);
				by = near_focus(fy, ny);
				bz = near_focus(fz, nz);
				w = $urandom_range(1, 4);
				h = $urandom_range(1, 4);
				d = $urandom_range(1, 2);
				paint = pick_density();
				for (int zz = bz; zz < bz + d && zz < SLICE_LIMIT; zz++)
					for (int yy = by; yy < by + h && yy < ROW_COUNT; yy++)
						for (int xx = bx; xx < bx + w && xx < ROW_LIMIT; xx++)
							queue_write(xx, yy, zz, fill_byte(paint));
				queue_query(bx, by, bz);
			end else if (roll < 65) begin
				queue_query(near_focus(fx, nx), near_focus(fy, ny), near_focus(fz, nz));
			end else if (roll < 80) begin
				queue_write($urandom_range(0, ROW_LIMIT - 1), $urandom_range(0, ROW_COUNT - 1),
					$urandom_range(0, SLICE_LIMIT - 1), VOXEL_W'($urandom_range(0, 255)));
			end else if (roll < 92 && (nx < ROW_LIMIT || ny < ROW_COUNT || nz < SLICE_LIMIT)) begin
				do begin
					qx = $urandom_range(0, ROW_LIMIT - 1);
					qy = $urandom_range(0, ROW_COUNT - 1);
					qz = $urandom_range(0, SLICE_LIMIT - 1);
				end while (qx < nx && qy < ny && qz < nz);
				queue_query(qx, qy, qz);
			end else begin
				queue_query(near_focus(fx, nx), near_focus(fy, ny), near_focus(fz, nz));
			end
		end
	endtask

	// Driver: presents the next beat at the falling edge once the previous one has been
	// taken, and holds it, valid high, for as long as the block stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			voxel_ch.valid <= 1'b0;
		end else if (beats_taken == beats_sent) begin
			if (send_gap > 0) begin
				send_gap--;
				voxel_ch.valid <= 1'b0;
			end else if (voxel_beats_q.size() != 0) begin
				next_beat = voxel_beats_q.pop_front();
				voxel_ch.valid       <= 1'b1;
				voxel_ch.action      <= next_beat.action;
				voxel_ch.pos_x       <= next_beat.pos_x;
				voxel_ch.pos_y       <= next_beat.pos_y;
				voxel_ch.pos_z       <= next_beat.pos_z;
				voxel_ch.voxel_value <= next_beat.voxel_value;
				beats_sent++;
				send_gap = pick_pause(send_steady);
			end else begin
				voxel_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: ready drops for random stretches regardless of what the block does.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			hold_left = pick_pause(ready_steady);
		end
	end

	// Monitor: follows register writes, updates the predicted volume on every write beat,
	// queues an answer for every query beat and checks each result beat against the
	// oldest answer. It also ends the run if the channels stay quiet for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			live_cfg = '{RST_OP_MODE, RST_WINDOW_RADIUS, RST_USE_DEPTH,
				RST_SIZE_X, RST_SIZE_Y, RST_SIZE_Z};
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_OP_MODE:       live_cfg.op_mode       = cfg_data[1:0];
					REG_WINDOW_RADIUS: live_cfg.window_radius = cfg_data[2:0];
					REG_USE_DEPTH:     live_cfg.use_depth     = cfg_data[0];
					REG_SIZE_X:        live_cfg.size_x        = cfg_data[6:0];
					REG_SIZE_Y:        live_cfg.size_y        = cfg_data[6:0];
					REG_SIZE_Z:        live_cfg.size_z        = cfg_data[4:0];
					default: ;
				endcase
			end
			if (voxel_ch.valid && voxel_ch.ready) begin
				beats_taken++;
				quiet_cycles = 0;
				if (voxel_ch.action == ACT_WRITE) begin
					shadow_volume[voxel_ch.pos_z][voxel_ch.pos_y][voxel_ch.pos_x] =
						(voxel_ch.voxel_value != '0);
				end else begin
					fresh_answer.pos_x      = voxel_ch.pos_x;
					fresh_answer.pos_y      = voxel_ch.pos_y;
					fresh_answer.pos_z      = voxel_ch.pos_z;
					fresh_answer.result_bit = box_result(voxel_ch.pos_x, voxel_ch.pos_y,
						voxel_ch.pos_z);
					pending_answers = {pending_answers, fresh_answer};
				end
			end
			if (result_ch.valid && result_ch.ready) begin
				quiet_cycles = 0;
				if (pending_answers.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("result beat %0b with no query outstanding",
							result_ch.result_bit);
				end else begin
					oldest_answer = pending_answers.pop_front();
					if (result_ch.result_bit !== oldest_answer.result_bit) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("query (%0d,%0d,%0d): expected %0b, got %0b",
								oldest_answer.pos_x, oldest_answer.pos_y,
								oldest_answer.pos_z, oldest_answer.result_bit,
								result_ch.result_bit);
					end
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("binary_box_morphology verification failed");
				$finish;
			end
		end
	end

	initial begin
		cfg_t plan [5];
		cfg_t setting;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_OP_MODE;
		cfg_data             = '0;
		voxel_ch.valid       = 1'b0;
		voxel_ch.action      = ACT_WRITE;
		voxel_ch.pos_x       = '0;
		voxel_ch.pos_y       = '0;
		voxel_ch.pos_z       = '0;
		voxel_ch.voxel_value = '0;
		result_ch.ready      = 1'b0;
		plan_cfg = '{RST_OP_MODE, RST_WINDOW_RADIUS, RST_USE_DEPTH,
			RST_SIZE_X, RST_SIZE_Y, RST_SIZE_Z};
		fill_density = 50;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Settings after reset: erode, radius one, in-slice, whole volume. A corner window
		// of four voxels all set erodes to one; the opposite corner with one set erodes to
		// zero. The write bytes cover single high and low bits as well as all ones.
		queue_write(0, 0, 0, 8'h01);
		queue_write(1, 0, 0, 8'h80);
		queue_write(0, 1, 0, 8'hFF);
		queue_write(1, 1, 0, 8'h7E);
		queue_query(0, 0, 0);
		queue_write(62, 62, 15, 8'h00);
		queue_write(63, 62, 15, 8'h00);
		queue_write(62, 63, 15, 8'h00);
		queue_write(63, 63, 15, 8'h10);
		queue_query(63, 63, 15);
		queue_query(63, 63, 15);
		run_phase(1'b0);

		// Fixed settings at the extremes: majority with a tie, the widest in-slice window,
		// the spare operation code with an oversized radius sweeping the full eleven by
		// eleven rows, zero sizes and radius that act as one, and oversized sizes.
		plan[0] = '{OP_MAJORITY, 3'd1, 1'b0, 7'd64, 7'd64, 5'd16};
		plan[1] = '{OP_DILATE, 3'd5, 1'b0, 7'd64, 7'd64, 5'd16};
		plan[2] = '{OP_SPARE, 3'd7, 1'b1, 7'd1, 7'd64, 5'd16};
		plan[3] = '{OP_ERODE, 3'd0, 1'b1, 7'd0, 7'd0, 5'd0};
		plan[4] = '{OP_DILATE, 3'd6, 1'b1, 7'd127, 7'd127, 5'd31};

		apply_setting(plan[0]);
		// Two ones and two zeros in the corner window is a tie, which votes one.
		queue_write(1, 0, 0, 8'h00);
		queue_write(0, 1, 0, 8'h00);
		queue_query(0, 0, 0);
		queue_write(1, 1, 0, 8'h00);
		queue_query(0, 0, 0);
		run_phase(1'b0);
		for (int i = 1; i < 5; i++) begin
			apply_setting(plan[i]);
			// A full-size window across slices is kept near a corner to bound the fill.
			run_phase(i == 4);
		end

		// Random settings until enough beats have gone in. Deep windows across many slices
		// would need hundreds of fill writes each, so they get only a few slices.
		while (stim_items < RANDOM_ITEMS) begin
			setting.op_mode       = 2'($urandom_range(0, 3));
			setting.window_radius = 3'($urandom_range(0, 7));
			setting.use_depth     = 1'($urandom_range(0, 1));
			setting.size_x        = 7'(pick_size(ROW_LIMIT, 127));
			setting.size_y        = 7'(pick_size(ROW_COUNT, 127));
			setting.size_z        = 5'(pick_size(SLICE_LIMIT, 31));
			if (setting.use_depth && setting.window_radius > 3'd2)
				setting.size_z = 5'($urandom_range(0, 2));
			apply_setting(setting);
			run_phase(1'b0);
		end

		settle(END_DRAIN);
		if (fail_count == 0 && pending_answers.size() == 0) begin
			$display("binary_box_morphology verification clean");
		end else begin
			$display("binary_box_morphology verification failed");
		end
		$finish;
	end

endmodule
